FILE: sv/ild_pkg.sv
// ild_pkg: shared types and constants for the interrupt level dispatch block
// holds the operation and outcome codes, the line code array and the search result struct
// no dependencies
`timescale 1ns / 1ps

package ild_pkg;

    // fixed geometry of the assignment words and the item fields
    localparam int WORD_COUNT = 8;
    localparam int WORD_W     = 32;
    localparam int CODE_W     = 4;
    localparam int CODES_PER_WORD = WORD_W / CODE_W;
    localparam int LINE_MAX   = WORD_COUNT * CODES_PER_WORD;
    localparam int LINE_IDX_W = 6;
    localparam int LEVEL_W    = 4;
    localparam int IRQ_W      = 7;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 4;

    // item operation codes
    typedef enum logic [0:0] {
        OP_DISPATCH = 1'b0,
        OP_UNMASK   = 1'b1
    } t_op;

    // result outcome codes
    typedef enum logic [1:0] {
        OUT_DISPATCHED = 2'd0,
        OUT_SPURIOUS   = 2'd1,
        OUT_RANGE      = 2'd2,
        OUT_UNMASKED   = 2'd3
    } t_outcome;

    // level code of every line, unpacked from the assignment words
    typedef logic [LINE_MAX-1:0][CODE_W-1:0] t_code_array;

    // result of the line search
    typedef struct packed {
        logic                  found;
        logic [LINE_IDX_W-1:0] line;
    } t_sel;

endpackage

FILE: sv/interrupt_level_dispatch.sv
// interrupt_level_dispatch: top level, item register, decode, state and result register
// uses ild_cfg_regs, ild_select and ild_pkg
`timescale 1ns / 1ps

// Routes a core interrupt level to a peripheral line.
// Input channel (i_in_valid / o_in_ready) carries one item: a dispatch of a level
// with the 64 raw pending bits, or an unmask of one line. Every item gives one
// result on the output channel (o_out_valid / i_out_ready): outcome, interrupt
// number and the spurious counter after the item.
// From acceptance the item sits in the item register, and the code compare and
// priority encode load the result register, which drives o_out_valid.
// Throughput is one item per cycle while the receiver takes results; the line search is a single parallel pass.
// Enable mask and spurious counter update as an item moves into the result
// register, so the next item always sees them.
// When the receiver stalls, the result holds and one more item waits in the item
// register; o_in_ready drops only when both are full.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and set one
// assignment word; indexes 8 and up are ignored. Write only while idle.
// Reset (synchronous, active low) clears the words, the mask and the counter
// and empties both registers.

module interrupt_level_dispatch #(
    parameter int LINE_COUNT   = 64,
    parameter int FIRST_LEVEL  = 7,
    parameter int LAST_LEVEL   = 13,
    parameter int TIMER_VECTOR = 6,
    parameter int TIMER_IRQ    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [ild_pkg::LEVEL_W-1:0]    i_level,
    input  logic [ild_pkg::LINE_MAX-1:0]   i_pending_lines,
    input  logic [ild_pkg::LINE_IDX_W-1:0] i_line_to_enable,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_outcome,
    output logic [ild_pkg::IRQ_W-1:0]      o_irq_number,
    output logic [ild_pkg::COUNT_W-1:0]    o_spurious_total,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ild_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ild_pkg::WORD_W-1:0]     i_cfg_data
);
    import ild_pkg::*;

    // item register
    logic                  r_a_valid;
    t_op                   r_a_op;
    logic [LEVEL_W-1:0]    r_a_level;
    logic [LINE_MAX-1:0]   r_a_pending;
    logic [LINE_IDX_W-1:0] r_a_line;

    // result register
    logic               r_b_valid;
    t_outcome           r_b_outcome;
    logic [IRQ_W-1:0]   r_b_irq;
    logic [COUNT_W-1:0] r_b_total;

    // block state
    logic [LINE_COUNT-1:0] r_mask;
    logic [LINE_COUNT-1:0] n_mask;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;

    t_outcome            n_outcome;
    logic [IRQ_W-1:0]    n_irq;
    logic                advance;
    logic                accept;
    logic [LINE_COUNT-1:0] active;
    logic [LINE_COUNT-1:0] set_bit;
    logic [CODE_W-1:0]   want;
    t_code_array         codes;
    t_sel                sel;

    // handshakes
    assign advance     = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready  = !r_a_valid || advance;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    ild_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_codes    (codes)
    );

    // line search inputs
    assign active = r_a_pending[LINE_COUNT-1:0] & r_mask;
    assign want   = CODE_W'(r_a_level - LEVEL_W'(FIRST_LEVEL));

    ild_select #(
        .LINE_COUNT (LINE_COUNT)
    ) u_select (
        .i_active (active),
        .i_want   (want),
        .i_codes  (codes),
        .o_sel    (sel)
    );

    // one-hot of the line to unmask, lines past the count give nothing
    always_comb begin
        for (int i = 0; i < LINE_COUNT; i++) begin
            set_bit[i] = (r_a_line == LINE_IDX_W'(i));
        end
    end

    // decode of the held item
    always_comb begin
        n_outcome = OUT_DISPATCHED;
        n_irq     = '0;
        n_mask    = r_mask;
        n_count   = r_count;
        if (r_a_op == OP_UNMASK) begin
            n_outcome = OUT_UNMASKED;
            n_mask    = r_mask | set_bit;
        end else if (r_a_level == LEVEL_W'(TIMER_VECTOR)) begin
            n_outcome = OUT_DISPATCHED;
            n_irq     = IRQ_W'(TIMER_IRQ);
        end else if (r_a_level < LEVEL_W'(FIRST_LEVEL) ||
                     r_a_level > LEVEL_W'(LAST_LEVEL)) begin
            n_outcome = OUT_RANGE;
        end else if (sel.found) begin
            n_outcome = OUT_DISPATCHED;
            n_irq     = IRQ_W'(FIRST_LEVEL) + IRQ_W'(sel.line);
        end else begin
            n_outcome = OUT_SPURIOUS;
            n_count   = r_count + COUNT_W'(1);
        end
    end

    // item register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    // item register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_op      <= t_op'(i_operation);
            r_a_level   <= i_level;
            r_a_pending <= i_pending_lines;
            r_a_line    <= i_line_to_enable;
        end
    end

    // result register control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_mask    <= '0;
            r_count   <= '0;
        end else begin
            if (advance) begin
                r_b_valid <= 1'b1;
                r_mask    <= n_mask;
                r_count   <= n_count;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_outcome <= n_outcome;
            r_b_irq     <= n_irq;
            r_b_total   <= n_count;
        end
    end

    assign o_out_valid      = r_b_valid;
    assign o_outcome        = r_b_outcome;
    assign o_irq_number     = r_b_irq;
    assign o_spurious_total = r_b_total;

    // enable bits are only ever set
    a_mask_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (($past(r_mask) & ~r_mask) == '0))
        else $error("enable mask lost a bit");

    // counter moves only with a spurious result that reports the new value
    a_count_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        (r_b_valid && r_b_outcome == OUT_SPURIOUS && r_b_total == r_count))
        else $error("spurious counter changed without a spurious result");

    // only a dispatch carries an interrupt number
    a_irq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_outcome != OUT_DISPATCHED) |-> (r_b_irq == '0))
        else $error("non-dispatch result with interrupt number");

    // a dispatched number is the timer or a line number
    a_irq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_outcome == OUT_DISPATCHED) |->
        (r_b_irq == IRQ_W'(TIMER_IRQ) || r_b_irq >= IRQ_W'(FIRST_LEVEL)))
        else $error("dispatched interrupt number below first level");

endmodule

FILE: sv/ild_cfg_regs.sv
// ild_cfg_regs: the eight level assignment words and their write port
// unpacks the words into one level code per line; depends on ild_pkg
`timescale 1ns / 1ps

module ild_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [ild_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [ild_pkg::WORD_W-1:0]    i_wr_data,
    output ild_pkg::t_code_array          o_codes
);
    import ild_pkg::*;

    logic [WORD_W-1:0] r_words [WORD_COUNT];

    // word write, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                r_words[w] <= '0;
            end
        end else if (i_wr_en) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                if (i_wr_index == CFG_IDX_W'(w)) begin
                    r_words[w] <= i_wr_data;
                end
            end
        end
    end

    // one 4-bit code per line
    always_comb begin
        for (int w = 0; w < WORD_COUNT; w++) begin
            for (int k = 0; k < CODES_PER_WORD; k++) begin
                o_codes[w*CODES_PER_WORD + k] = r_words[w][k*CODE_W +: CODE_W];
            end
        end
    end

endmodule

FILE: sv/ild_select.sv
// ild_select: parallel code compare and priority encode over the peripheral lines
// finds the lowest active line assigned to the wanted level code; depends on ild_pkg
`timescale 1ns / 1ps

module ild_select #(
    parameter int LINE_COUNT = 64
) (
    input  logic [LINE_COUNT-1:0]      i_active,
    input  logic [ild_pkg::CODE_W-1:0] i_want,
    input  ild_pkg::t_code_array       i_codes,
    output ild_pkg::t_sel              o_sel
);
    import ild_pkg::*;

    logic [LINE_COUNT-1:0] match;

    // per-line hit
    always_comb begin
        for (int i = 0; i < LINE_COUNT; i++) begin
            match[i] = i_active[i] && (i_codes[i] == i_want);
        end
    end

    // lowest-numbered hit wins
    always_comb begin
        o_sel.found = |match;
        o_sel.line  = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_sel.line = LINE_IDX_W'(i);
            end
        end
    end

endmodule

FILE: dv/tb_interrupt_level_dispatch.sv
// tb_interrupt_level_dispatch: self-checking testbench for interrupt_level_dispatch
// predicts every result in a small scoreboard class and compares it field by field
// depends on ild_pkg and interrupt_level_dispatch
`timescale 1ns / 1ps

module tb_interrupt_level_dispatch;
    import ild_pkg::*;

    localparam int LINE_COUNT   = 64;
    localparam int FIRST_LEVEL  = 7;
    localparam int LAST_LEVEL   = 13;
    localparam int TIMER_VECTOR = 6;
    localparam int TIMER_IRQ    = 6;

    localparam int RANDOM_PER_PHASE = 140;
    localparam int PHASE_COUNT      = 8;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 500000;

    // how the level codes of a phase are chosen
    typedef enum int {
        CODES_ZERO,
        CODES_FULL,
        CODES_VALID,
        CODES_STRIPE,
        CODES_NEAR,
        CODES_RAW
    } t_code_plan;

    typedef struct {
        t_outcome                outcome;
        logic [IRQ_W-1:0]        irq;
        logic [COUNT_W-1:0]      total;
    } t_route;

    // predicted routing state and the results still awaited
    class dispatch_scoreboard;
        logic [WORD_W-1:0]   assign_words [WORD_COUNT];
        logic [LINE_MAX-1:0] enable_mask;
        logic [COUNT_W-1:0]  spurious_count;
        t_route              awaited_routes [$];
        int                  mismatches;

        function new();
            foreach (assign_words[i]) assign_words[i] = '0;
            enable_mask    = '0;
            spurious_count = '0;
            mismatches     = 0;
        endfunction

        function void set_word(int idx, logic [WORD_W-1:0] data);
            if (idx < WORD_COUNT) assign_words[idx] = data;
        endfunction

        // route one accepted item and queue its result
        function void note_item(t_op op, logic [LEVEL_W-1:0] lvl,
                                logic [LINE_MAX-1:0] pend, logic [LINE_IDX_W-1:0] ln);
            t_route              r;
            logic [LINE_MAX-1:0] active;
            logic [WORD_W-1:0]   w;
            logic [CODE_W-1:0]   code;
            int                  want;
            int                  n;
            bit                  hit;
            r.irq = '0;
            hit   = 1'b0;
            if (op == OP_UNMASK) begin
                if (ln < LINE_COUNT) enable_mask[ln] = 1'b1;
                r.outcome = OUT_UNMASKED;
            end else if (lvl == TIMER_VECTOR) begin
                r.outcome = OUT_DISPATCHED;
                r.irq     = IRQ_W'(TIMER_IRQ);
            end else if (lvl < FIRST_LEVEL || lvl > LAST_LEVEL) begin
                r.outcome = OUT_RANGE;
            end else begin
                want   = int'(lvl) - FIRST_LEVEL;
                active = pend & enable_mask;
                // lowest pending, enabled line on the wanted level
                for (n = 0; n < LINE_COUNT; n++) begin
                    w    = assign_words[n / 8];
                    code = w[(n % 8) * 4 +: 4];
                    if (!hit && active[n] && code == want) begin
                        hit   = 1'b1;
                        r.irq = IRQ_W'(FIRST_LEVEL + n);
                    end
                end
                if (hit) begin
                    r.outcome = OUT_DISPATCHED;
                end else begin
                    r.outcome      = OUT_SPURIOUS;
                    spurious_count = spurious_count + 1'b1;
                end
            end
            r.total = spurious_count;
            awaited_routes.push_back(r);
        endfunction

        function void check_result(logic [1:0] outcome, logic [IRQ_W-1:0] irq,
                                   logic [COUNT_W-1:0] total);
            t_route r;
            if (awaited_routes.size() == 0) begin
                $display("%0t: result with no item waiting: outcome %0d irq %0d total %0d",
                         $time, outcome, irq, total);
                mismatches++;
                return;
            end
            r = awaited_routes.pop_front();
            if (outcome !== r.outcome) begin
                $display("%0t: outcome expected %0d actual %0d", $time, r.outcome, outcome);
                mismatches++;
            end
            if (irq !== r.irq) begin
                $display("%0t: irq_number expected %0d actual %0d", $time, r.irq, irq);
                mismatches++;
            end
            if (total !== r.total) begin
                $display("%0t: spurious_total expected %0d actual %0d",
                         $time, r.total, total);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return awaited_routes.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_operation;
    logic [LEVEL_W-1:0]    i_level;
    logic [LINE_MAX-1:0]   i_pending_lines;
    logic [LINE_IDX_W-1:0] i_line_to_enable;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_outcome;
    logic [IRQ_W-1:0]      o_irq_number;
    logic [COUNT_W-1:0]    o_spurious_total;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [WORD_W-1:0]     i_cfg_data;

    dispatch_scoreboard sb;
    bit                 sender_idles;
    bit                 receiver_idles;
    bit                 hold_request;
    int                 cycle_count;
    t_code_plan         plans [PHASE_COUNT];

    interrupt_level_dispatch #(
        .LINE_COUNT   (LINE_COUNT),
        .FIRST_LEVEL  (FIRST_LEVEL),
        .LAST_LEVEL   (LAST_LEVEL),
        .TIMER_VECTOR (TIMER_VECTOR),
        .TIMER_IRQ    (TIMER_IRQ)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_level          (i_level),
        .i_pending_lines  (i_pending_lines),
        .i_line_to_enable (i_line_to_enable),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_irq_number     (o_irq_number),
        .o_spurious_total (o_spurious_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // results are taken at the next rising edge, so sample between edges
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_outcome, o_irq_number, o_spurious_total);
    end

    // mostly zero, some short gaps, a few long ones
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // result receiver with random stalls and one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(receiver_idles);
                i_out_ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // offer one item and hold it until accepted, then maybe pause
    task automatic send_item(input t_op op, input logic [LEVEL_W-1:0] lvl,
                             input logic [LINE_MAX-1:0] pend,
                             input logic [LINE_IDX_W-1:0] ln);
        bit taken;
        int gap;
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_level          <= lvl;
        i_pending_lines  <= pend;
        i_line_to_enable <= ln;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_item(op, lvl, pend, ln);
        gap = pick_gap(sender_idles);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one register write, valid is left high for a following write
    task automatic write_word(input int idx, input logic [WORD_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        sb.set_word(idx, data);
    endtask

    // load all eight assignment words, plus one write to an unused index
    task automatic program_assignment(input t_code_plan plan);
        logic [WORD_W-1:0] w;
        logic [CODE_W-1:0] c;
        int                i;
        int                n;
        for (i = 0; i < WORD_COUNT; i++) begin
            for (n = 0; n < CODES_PER_WORD; n++) begin
                case (plan)
                    CODES_ZERO:   c = '0;
                    CODES_FULL:   c = '1;
                    CODES_VALID:  c = CODE_W'($urandom_range(0, LAST_LEVEL - FIRST_LEVEL));
                    CODES_STRIPE: c = CODE_W'((i * 8 + n) % (LAST_LEVEL - FIRST_LEVEL + 1));
                    CODES_NEAR:   c = CODE_W'($urandom_range(0, LAST_LEVEL - FIRST_LEVEL + 1));
                    default:      c = CODE_W'($urandom_range(0, 15));
                endcase
                w[n * CODE_W +: CODE_W] = c;
            end
            write_word(i, w);
        end
        write_word($urandom_range(WORD_COUNT, 15), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [LINE_MAX-1:0] pick_pending();
        logic [LINE_MAX-1:0] p;
        int                  r;
        int                  k;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            p = '0;
        end else if (r < 20) begin
            p = '1;
        end else if (r < 40) begin
            p = LINE_MAX'(1) << $urandom_range(0, LINE_MAX - 1);
        end else if (r < 60) begin
            p = '0;
            for (k = 0; k < $urandom_range(2, 4); k++)
                p[$urandom_range(0, LINE_MAX - 1)] = 1'b1;
        end else begin
            p = {$urandom, $urandom};
        end
        return p;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return LEVEL_W'($urandom_range(FIRST_LEVEL, LAST_LEVEL));
        if (r < 80) return LEVEL_W'(TIMER_VECTOR);
        return LEVEL_W'($urandom_range(0, 15));
    endfunction

    task automatic run_random(input int count, input int unmask_pct);
        t_op op;
        int  k;
        for (k = 0; k < count; k++) begin
            op = ($urandom_range(0, 99) < unmask_pct) ? OP_UNMASK : OP_DISPATCH;
            send_item(op, pick_level(), pick_pending(),
                      LINE_IDX_W'($urandom_range(0, LINE_MAX - 1)));
        end
    endtask

    // reset codes put every line on the first level
    task automatic run_directed();
        send_item(OP_DISPATCH, 4'd7, '1, '0);              // all lines masked
        send_item(OP_DISPATCH, LEVEL_W'(TIMER_VECTOR), '0, '0);
        send_item(OP_DISPATCH, 4'd0, '1, '0);              // below range
        send_item(OP_DISPATCH, 4'd5, '1, '0);
        send_item(OP_DISPATCH, 4'd14, '1, '0);             // above range
        send_item(OP_DISPATCH, 4'd15, '1, '1);
        send_item(OP_UNMASK, 4'd0, '0, 6'd0);
        send_item(OP_UNMASK, 4'd15, '1, 6'd63);
        send_item(OP_DISPATCH, 4'd7, '1, '0);              // lowest line wins
        send_item(OP_DISPATCH, 4'd7, 64'h8000_0000_0000_0000, '0);
        send_item(OP_DISPATCH, 4'd7, '0, '0);
        send_item(OP_DISPATCH, 4'd8, '1, '0);              // no line on that level
        send_item(OP_DISPATCH, 4'd13, '1, '0);
        send_item(OP_UNMASK, 4'd0, '0, 6'd0);              // already enabled
        send_item(OP_UNMASK, 4'd9, 64'h5555_aaaa_5555_aaaa, 6'd42);
        send_item(OP_DISPATCH, 4'd7, 64'h8000_0400_0000_0000, '0);
        send_item(OP_DISPATCH, 4'd7, 64'h7fff_fbff_ffff_fffe, '0);
        send_item(OP_DISPATCH, LEVEL_W'(TIMER_VECTOR), '1, '1);
        send_item(OP_DISPATCH, 4'd7, 64'h0000_0000_0000_0001, '0);
    endtask

    // main sequence
    initial begin
        int p;
        sb = new();
        plans = '{CODES_VALID, CODES_ZERO, CODES_FULL, CODES_STRIPE,
                  CODES_RAW, CODES_NEAR, CODES_VALID, CODES_RAW};
        sender_idles     = 1'b0;
        receiver_idles   = 1'b0;
        hold_request     = 1'b0;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= OP_DISPATCH;
        i_level          <= '0;
        i_pending_lines  <= '0;
        i_line_to_enable <= '0;
        i_out_ready      <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        i_in_valid <= 1'b0;
        wait_drained();

        for (p = 0; p < PHASE_COUNT; p++) begin
            program_assignment(plans[p]);
            // two phases run back to back with no idling at all
            sender_idles   = (p != 1 && p != 5);
            receiver_idles = (p != 1 && p != 5);
            if (p == 3) hold_request = 1'b1;
            run_random(RANDOM_PER_PHASE, (p < 4) ? 4 : 9);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: interrupt_level_dispatch.f
sv/ild_pkg.sv
sv/ild_cfg_regs.sv
sv/ild_select.sv
sv/interrupt_level_dispatch.sv
dv/tb_interrupt_level_dispatch.sv
